### src/fbpu_pkg.sv
package fbpu_pkg;

	localparam int MAX_DIM       = 4096;
	localparam int DIM_W         = 13;
	localparam int COORD_W       = 12;
	localparam int ADDR_W        = 24;
	localparam int PAL_W         = 8;
	localparam int PALETTE_DEPTH = 2 ** PAL_W;
	localparam int PCOUNT_W      = PAL_W + 1;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 13;

	localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

	// input item kinds
	localparam logic FUNC_DATA    = 1'b0;
	localparam logic FUNC_PALETTE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 3'd5;

	typedef enum logic [2:0] {
		FMT_MONO1    = 3'd0,
		FMT_PAL2     = 3'd1,
		FMT_PAL4     = 3'd2,
		FMT_PAL8     = 3'd3,
		FMT_RGB565   = 3'd4,
		FMT_RGB888   = 3'd5,
		FMT_RGBA8888 = 3'd6,
		FMT_UNDEF    = 3'd7
	} fmt_t;

	// one input byte that yields at least one pixel
	typedef struct packed {
		logic               use_pal;
		logic [2:0]         fmt;
		logic [7:0]         pix_byte;
		logic [3:0]         count;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [ADDR_W-1:0]  row_base;
		logic [31:0]        direct;
	} job_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		return (v > MAX_DIM_V) ? MAX_DIM_V : v;
	endfunction

	function automatic logic [DIM_W-1:0] min_dim(input logic [DIM_W-1:0] a,
	                                             input logic [DIM_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

### src/fbpu_ifs.sv
interface fbpu_stream_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  data_byte;
	logic [7:0]  entry_slot;
	logic [31:0] entry_color;

	modport source(output valid, func, data_byte, entry_slot, entry_color, input ready);
	modport sink(input valid, func, data_byte, entry_slot, entry_color, output ready);
endinterface

interface fbpu_pixel_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_rgba;
	logic [11:0] dest_x;
	logic [11:0] dest_y;
	logic [23:0] dest_address;
	logic        run_last;

	modport source(output valid, pixel_rgba, dest_x, dest_y, dest_address, run_last,
	               input ready);
	modport sink(input valid, pixel_rgba, dest_x, dest_y, dest_address, run_last,
	             output ready);
endinterface

interface fbpu_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [12:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### src/fbpu_front.sv
module fbpu_front
	import fbpu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	fbpu_cfg_if.sink         cfg,
	input  logic             take,
	input  logic             func,
	input  logic [7:0]       data_byte,
	output job_t             job,
	output logic             job_valid
);

	logic [2:0]          fmt_q;
	logic [DIM_W-1:0]    sw_q, sh_q, dw_q, dh_q;
	logic [PCOUNT_W-1:0] pcount_q;
	logic [DIM_W-1:0]    col_q, row_q;
	logic [1:0]          phase_q;
	logic [23:0]         gather_q;

	logic [DIM_W-1:0] sw_c, sh_c, dw_c, dh_c, cw, ch, remaining, col_sum;
	logic [3:0]       ppb, n_packed, step;
	logic             active, packed_fmt, pal_ok, in_crop, final_byte, emit;
	logic [1:0]       last_phase;
	logic [23:0]      gather_next;
	logic [31:0]      direct;
	logic [ADDR_W-1:0] product;

	assign cfg.ready = 1'b1;

	assign sw_c = clamp_dim(sw_q);
	assign sh_c = clamp_dim(sh_q);
	assign dw_c = clamp_dim(dw_q);
	assign dh_c = clamp_dim(dh_q);
	assign cw   = min_dim(sw_c, dw_c);
	assign ch   = min_dim(sh_c, dh_c);

	assign active     = (func == FUNC_DATA) && (sw_c != '0) && (sh_c != '0) &&
	                    (fmt_q != FMT_UNDEF);
	assign packed_fmt = (fmt_q == FMT_MONO1) || (fmt_q == FMT_PAL2) || (fmt_q == FMT_PAL4);
	assign in_crop    = (col_q < cw) && (row_q < ch);
	assign remaining  = cw - col_q;

	always_comb begin
		case (fmt_q)
			FMT_MONO1: begin
				ppb        = 4'd8;
				pal_ok     = pcount_q >= PCOUNT_W'(2);
				last_phase = 2'd0;
			end
			FMT_PAL2: begin
				ppb        = 4'd4;
				pal_ok     = pcount_q >= PCOUNT_W'(4);
				last_phase = 2'd0;
			end
			FMT_PAL4: begin
				ppb        = 4'd2;
				pal_ok     = pcount_q >= PCOUNT_W'(16);
				last_phase = 2'd0;
			end
			FMT_PAL8: begin
				ppb        = 4'd1;
				pal_ok     = {1'b0, data_byte} < pcount_q;
				last_phase = 2'd0;
			end
			FMT_RGB565: begin
				ppb        = 4'd1;
				pal_ok     = 1'b1;
				last_phase = 2'd1;
			end
			FMT_RGB888: begin
				ppb        = 4'd1;
				pal_ok     = 1'b1;
				last_phase = 2'd2;
			end
			default: begin
				ppb        = 4'd1;
				pal_ok     = (sw_q == dw_q) && (sh_q == dh_q);
				last_phase = 2'd3;
			end
		endcase
	end

	assign final_byte = phase_q >= last_phase;
	assign n_packed   = (remaining < DIM_W'(ppb)) ? remaining[3:0] : ppb;
	assign step       = packed_fmt ? ppb : 4'd1;
	assign col_sum    = col_q + DIM_W'(step);

	always_comb begin
		gather_next = gather_q;
		case (phase_q)
			2'd0:    gather_next[7:0]   = data_byte;
			2'd1:    gather_next[15:8]  = data_byte;
			default: gather_next[23:16] = data_byte;
		endcase
	end

	// colour for the formats that carry it in the stream
	always_comb begin
		case (fmt_q)
			FMT_RGB565: direct = {8'hFF, gather_q[4:0], 3'b000,
			                      data_byte[2:0], gather_q[7:5], 2'b00,
			                      data_byte[7:3], 3'b000};
			FMT_RGB888: direct = {8'hFF, data_byte, gather_q[15:8], gather_q[7:0]};
			default:    direct = {data_byte, gather_q};
		endcase
	end

	assign emit      = active && in_crop && pal_ok && (packed_fmt || final_byte);
	assign job_valid = take && emit;

	// row start address, both operands widened so no product bit is lost
	assign product = ADDR_W'(row_q[COORD_W-1:0]) * ADDR_W'(dw_c);

	always_comb begin
		job.use_pal  = packed_fmt || (fmt_q == FMT_PAL8);
		job.fmt      = fmt_q;
		job.pix_byte = data_byte;
		job.count    = packed_fmt ? n_packed : 4'd1;
		job.x        = col_q[COORD_W-1:0];
		job.y        = row_q[COORD_W-1:0];
		job.row_base = product;
		job.direct   = direct;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= '0;
			sw_q     <= '0;
			sh_q     <= '0;
			dw_q     <= '0;
			dh_q     <= '0;
			pcount_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			phase_q  <= '0;
			gather_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_PIXEL_FORMAT:  fmt_q    <= cfg.data[2:0];
				CFG_SOURCE_WIDTH:  sw_q     <= cfg.data[DIM_W-1:0];
				CFG_SOURCE_HEIGHT: sh_q     <= cfg.data[DIM_W-1:0];
				CFG_DEST_WIDTH:    dw_q     <= cfg.data[DIM_W-1:0];
				CFG_DEST_HEIGHT:   dh_q     <= cfg.data[DIM_W-1:0];
				CFG_PALETTE_COUNT: pcount_q <= cfg.data[PCOUNT_W-1:0];
				default: ;
			endcase
			// format and geometry writes restart the frame
			if (cfg.index != CFG_PALETTE_COUNT && cfg.index <= CFG_DEST_HEIGHT) begin
				col_q    <= '0;
				row_q    <= '0;
				phase_q  <= '0;
				gather_q <= '0;
			end
		end else if (take && active) begin
			if (!packed_fmt && fmt_q != FMT_PAL8 && !final_byte) begin
				gather_q <= gather_next;
				phase_q  <= phase_q + 2'd1;
			end else begin
				phase_q  <= '0;
				gather_q <= '0;
				if (col_sum >= sw_c) begin
					col_q <= '0;
					row_q <= (row_q + 1'b1 >= sh_c) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_sum;
				end
			end
		end
	end

endmodule

### src/framebuffer_pixel_unpacker.sv
// channel   | role   | payload
// ----------+--------+-----------------------------------------------------------
// stream    | sink   | func, data_byte, entry_slot, entry_color
// pixel     | source | pixel_rgba, dest_x, dest_y, dest_address, run_last
// cfg       | sink   | index, data (always ready)
//
// one input transfer per cycle while each byte yields at most one pixel and the pixel output is not stalled
// packed palette bytes hold the issue stage until every pixel kept (1..8) has issued,
// set by the single read port of the palette memory: one pixel per cycle while the output is not stalled
// bytes that yield no pixel and palette writes do not occupy the issue stage
// arst_n clears position, configuration registers and valid flags; palette contents stay undefined
// a stalled pixel output holds the issue stage; stream ready drops only when it is full
module framebuffer_pixel_unpacker
	import fbpu_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	fbpu_stream_if.sink   stream,
	fbpu_pixel_if.source  pixel,
	fbpu_cfg_if.sink      cfg
);

	// palette store, written on palette transfers, read once per issued pixel
	logic [31:0] palette_mem [PALETTE_DEPTH];
	logic [31:0] rd_q;

	job_t job;
	logic job_valid, take;

	// issue stage: one byte's pixels, walked one per cycle while the output stage can advance
	logic               valid_s1;
	logic               use_pal_s1;
	logic [2:0]         fmt_s1;
	logic [7:0]         byte_s1;
	logic [3:0]         cnt_s1;
	logic [COORD_W-1:0] x_s1, y_s1;
	logic [ADDR_W-1:0]  row_base_s1;
	logic [31:0]        direct_s1;

	// output stage
	logic               valid_s2;
	logic               use_pal_s2;
	logic [31:0]        direct_s2;
	logic [COORD_W-1:0] x_s2, y_s2;
	logic [ADDR_W-1:0]  addr_s2;
	logic               last_s2;

	logic             adv2, issue, last_issue;
	logic [PAL_W-1:0] idx;
	logic [7:0]       byte_shift;

	fbpu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.take      (take),
		.func      (stream.func),
		.data_byte (stream.data_byte),
		.job       (job),
		.job_valid (job_valid)
	);

	// handshake across the two stages
	assign adv2         = !valid_s2 || pixel.ready;
	assign issue        = valid_s1 && adv2;
	assign last_issue   = issue && (cnt_s1 == 4'd1);
	assign stream.ready = !valid_s1 || last_issue;
	assign take         = stream.valid && stream.ready;

	// palette index sits in the top bits of the shifted byte
	always_comb begin
		case (fmt_s1)
			FMT_MONO1: begin
				idx        = PAL_W'(byte_s1[7]);
				byte_shift = {byte_s1[6:0], 1'b0};
			end
			FMT_PAL2: begin
				idx        = PAL_W'(byte_s1[7:6]);
				byte_shift = {byte_s1[5:0], 2'b00};
			end
			FMT_PAL4: begin
				idx        = PAL_W'(byte_s1[7:4]);
				byte_shift = {byte_s1[3:0], 4'b0000};
			end
			default: begin
				idx        = byte_s1;
				byte_shift = byte_s1;
			end
		endcase
	end

	// palette memory: read before write on a shared edge
	always_ff @(posedge clk) begin
		if (issue)
			rd_q <= palette_mem[idx];
		if (take && stream.func == FUNC_PALETTE)
			palette_mem[stream.entry_slot] <= stream.entry_color;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take && job_valid)
				valid_s1 <= 1'b1;
			else if (last_issue)
				valid_s1 <= 1'b0;

			if (issue)
				valid_s2 <= 1'b1;
			else if (pixel.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && job_valid) begin
			use_pal_s1  <= job.use_pal;
			fmt_s1      <= job.fmt;
			byte_s1     <= job.pix_byte;
			cnt_s1      <= job.count;
			x_s1        <= job.x;
			y_s1        <= job.y;
			row_base_s1 <= job.row_base;
			direct_s1   <= job.direct;
		end else if (issue) begin
			byte_s1 <= byte_shift;
			cnt_s1  <= cnt_s1 - 4'd1;
			x_s1    <= x_s1 + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			use_pal_s2 <= use_pal_s1;
			direct_s2  <= direct_s1;
			x_s2       <= x_s1;
			y_s2       <= y_s1;
			addr_s2    <= row_base_s1 + ADDR_W'(x_s1);
			last_s2    <= cnt_s1 == 4'd1;
		end
	end

	assign pixel.valid        = valid_s2;
	assign pixel.pixel_rgba   = use_pal_s2 ? rd_q : direct_s2;
	assign pixel.dest_x       = x_s2;
	assign pixel.dest_y       = y_s2;
	assign pixel.dest_address = addr_s2;
	assign pixel.run_last     = last_s2;

endmodule
